// ===== design/pca_pkg.sv =====
package pca_pkg;

   localparam int FRAC_BITS = 16;

   localparam logic [2:0] REG_KP    = 3'd0;
   localparam logic [2:0] REG_KI    = 3'd1;
   localparam logic [2:0] REG_KD    = 3'd2;
   localparam logic [2:0] REG_T     = 3'd3;
   localparam logic [2:0] REG_TAU   = 3'd4;
   localparam logic [2:0] REG_OMAX  = 3'd5;
   localparam logic [2:0] REG_OMIN  = 3'd6;
   localparam logic [2:0] REG_ILIM  = 3'd7;

   localparam logic OP_COMPUTE = 1'b0;
   localparam logic OP_CLEAR   = 1'b1;

   typedef struct packed {
      logic               opcode;
      logic signed [31:0] setpoint;
      logic signed [31:0] measurement;
   } req_type;

   typedef struct packed {
      logic signed [31:0] drive;
      logic signed [31:0] prop_term;
      logic signed [31:0] integ_term;
      logic signed [31:0] deriv_term;
      logic               saturated;
   } rsp_type;

   typedef struct packed {
      logic [30:0]        kp;
      logic [30:0]        ki;
      logic [30:0]        kd;
      logic [30:0]        t;
      logic [30:0]        tau;
      logic signed [31:0] omax;
      logic signed [31:0] omin;
      logic [63:0]        ilim;
   } cfg_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_CLEAR, ST_ERR, ST_MUL_P, ST_MUL_KT, ST_MUL_I, ST_INT,
      ST_MUL_A, ST_MUL_B, ST_NUM, ST_DIV, ST_DIV_END, ST_SUM, ST_BACK,
      ST_COMMIT, ST_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic clear;
      logic err;
      logic mul_p;
      logic mul_kt;
      logic mul_i;
      logic integ;
      logic mul_a;
      logic mul_b;
      logic num;
      logic div_step;
      logic div_end;
      logic sum;
      logic back;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic div_done;
   } status_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > 66'sd2147483647) return 32'sh7fffffff;
      if (v < -66'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

endpackage

// ===== design/pca_ctrl.sv =====
module pca_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_opcode,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  pca_pkg::status_type    status,
   output pca_pkg::cmd_type       cmd
);

   pca_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pca_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pca_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_opcode == pca_pkg::OP_CLEAR) ? pca_pkg::ST_CLEAR
                                                             : pca_pkg::ST_ERR;
            end
         end
         pca_pkg::ST_CLEAR:   state_in = pca_pkg::ST_OUT;
         pca_pkg::ST_ERR:     state_in = pca_pkg::ST_MUL_P;
         pca_pkg::ST_MUL_P:   state_in = pca_pkg::ST_MUL_KT;
         pca_pkg::ST_MUL_KT:  state_in = pca_pkg::ST_MUL_I;
         pca_pkg::ST_MUL_I:   state_in = pca_pkg::ST_INT;
         pca_pkg::ST_INT:     state_in = pca_pkg::ST_MUL_A;
         pca_pkg::ST_MUL_A:   state_in = pca_pkg::ST_MUL_B;
         pca_pkg::ST_MUL_B:   state_in = pca_pkg::ST_NUM;
         pca_pkg::ST_NUM:     state_in = pca_pkg::ST_DIV;
         pca_pkg::ST_DIV: begin
            if (status.div_done) state_in = pca_pkg::ST_DIV_END;
         end
         pca_pkg::ST_DIV_END: state_in = pca_pkg::ST_SUM;
         pca_pkg::ST_SUM:     state_in = pca_pkg::ST_BACK;
         pca_pkg::ST_BACK:    state_in = pca_pkg::ST_COMMIT;
         pca_pkg::ST_COMMIT:  state_in = pca_pkg::ST_OUT;
         pca_pkg::ST_OUT: begin
            if (!rsp_stall) state_in = pca_pkg::ST_IDLE;
         end
         default: state_in = pca_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         pca_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load = req_valid;
         end
         pca_pkg::ST_CLEAR:   cmd.clear = 1'b1;
         pca_pkg::ST_ERR:     cmd.err = 1'b1;
         pca_pkg::ST_MUL_P:   cmd.mul_p = 1'b1;
         pca_pkg::ST_MUL_KT:  cmd.mul_kt = 1'b1;
         pca_pkg::ST_MUL_I:   cmd.mul_i = 1'b1;
         pca_pkg::ST_INT:     cmd.integ = 1'b1;
         pca_pkg::ST_MUL_A:   cmd.mul_a = 1'b1;
         pca_pkg::ST_MUL_B:   cmd.mul_b = 1'b1;
         pca_pkg::ST_NUM:     cmd.num = 1'b1;
         pca_pkg::ST_DIV:     cmd.div_step = 1'b1;
         pca_pkg::ST_DIV_END: cmd.div_end = 1'b1;
         pca_pkg::ST_SUM:     cmd.sum = 1'b1;
         pca_pkg::ST_BACK:    cmd.back = 1'b1;
         pca_pkg::ST_COMMIT:  cmd.commit = 1'b1;
         pca_pkg::ST_OUT:     rsp_valid = 1'b1;
         default: ;
      endcase
   end

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != pca_pkg::ST_IDLE) |-> req_stall)
      else $error("input taken while busy");
   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("result dropped under stall");
   a_div_to_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pca_pkg::ST_DIV && status.div_done) |=> cmd.div_end)
      else $error("division end skipped");

endmodule

// ===== design/pca_datapath.sv =====
module pca_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  pca_pkg::req_type     req_data,
   input  pca_pkg::cfg_type     cfg,
   input  pca_pkg::cmd_type     cmd,
   output pca_pkg::status_type  status,
   output pca_pkg::rsp_type     rsp_data
);

   localparam int F = pca_pkg::FRAC_BITS;
   localparam int NUMW = 33 + F;

   logic signed [31:0] sp_ff, m_ff, e_ff, p_ff, kt_ff, i_ff, d_ff, o_ff, a_ff, b_ff;
   logic signed [31:0] last_e_ff, last_m_ff, integ_ff, filt_d_ff;
   logic               sat_ff;
   logic signed [31:0] den_ff;
   logic               neg_ff;
   logic [NUMW-1:0]    quo_ff, rem_num_ff;
   logic [32:0]        rem_ff;
   logic [5:0]         cnt_ff;
   logic signed [63:0] prod_ff;

   logic signed [32:0] ma, mb;
   logic signed [65:0] prod;
   logic signed [31:0] integ_sum, s, o, lo, hi, c, den, q_sat;
   logic signed [65:0] num_full;
   logic [33:0]        rem_try;
   logic [NUMW:0]      qmag;

   always_comb begin
      ma = '0;
      mb = '0;
      if (cmd.mul_p) begin
         ma = {2'b0, cfg.kp};
         mb = {e_ff[31], e_ff};
      end else if (cmd.mul_kt) begin
         ma = {2'b0, cfg.ki};
         mb = {2'b0, cfg.t};
      end else if (cmd.mul_i) begin
         ma = {kt_ff[31], kt_ff};
         mb = 33'(e_ff) + 33'(last_e_ff);
      end else if (cmd.mul_a) begin
         ma = {2'b0, cfg.kd};
         mb = {m_ff[31], m_ff};
      end else begin
         ma = {c[31], c};
         mb = {filt_d_ff[31], filt_d_ff};
      end
   end
   assign prod = 66'(ma) * 66'(mb);

   assign c   = pca_pkg::sat32(66'sd2 * $signed({35'b0, cfg.tau})
                               - $signed({35'b0, cfg.t}));
   assign den = pca_pkg::sat32(66'sd2 * $signed({35'b0, cfg.tau})
                               + $signed({35'b0, cfg.t}));

   assign lo = cfg.ilim[31:0];
   assign hi = cfg.ilim[63:32];
   always_comb begin
      integ_sum = pca_pkg::sat32(66'(integ_ff) + 66'(pca_pkg::sat32(66'(prod_ff))));
      if (lo != hi) begin
         if (integ_sum < lo) integ_sum = lo;
         if (integ_sum > hi) integ_sum = hi;
      end
   end

   assign num_full = (66'(a_ff) + 66'(b_ff)) <<< F;
   assign rem_try  = {rem_ff, rem_num_ff[NUMW-1]} - {2'b0, den_ff};
   assign qmag     = {1'b0, quo_ff};
   assign q_sat    = neg_ff ? pca_pkg::sat32(-$signed(66'(qmag)))
                            : pca_pkg::sat32($signed(66'(qmag)));

   assign s = pca_pkg::sat32(66'(p_ff) + 66'(i_ff) + 66'(d_ff));
   always_comb begin
      o = s;
      if (o < cfg.omin) o = cfg.omin;
      if (o > cfg.omax) o = cfg.omax;
   end

   assign status.div_done = (cnt_ff == 6'(NUMW - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         last_e_ff <= '0;
         last_m_ff <= '0;
         integ_ff  <= '0;
         filt_d_ff <= '0;
      end else if (cmd.clear) begin
         last_e_ff <= '0;
         last_m_ff <= '0;
         integ_ff  <= '0;
         filt_d_ff <= '0;
      end else if (cmd.commit) begin
         last_e_ff <= e_ff;
         last_m_ff <= sp_ff;
         integ_ff  <= i_ff;
         filt_d_ff <= d_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sp_ff <= req_data.setpoint;
         m_ff  <= req_data.measurement;
      end
      if (cmd.clear) begin
         o_ff <= '0;
         p_ff <= '0;
         i_ff <= '0;
         d_ff <= '0;
         sat_ff <= 1'b0;
      end
      if (cmd.err) begin
         e_ff <= pca_pkg::sat32(66'(sp_ff) - 66'(m_ff));
         sp_ff <= m_ff;
         m_ff <= pca_pkg::sat32(66'(m_ff) - 66'(last_m_ff));
      end
      if (cmd.mul_p) p_ff <= pca_pkg::sat32(prod >>> F);
      if (cmd.mul_kt) kt_ff <= pca_pkg::sat32(prod >>> F);
      if (cmd.mul_i) prod_ff <= 64'(pca_pkg::sat32(prod >>> (F + 1)));
      if (cmd.integ) i_ff <= integ_sum;
      if (cmd.mul_a) a_ff <= pca_pkg::sat32(prod >>> (F - 1));
      if (cmd.mul_b) b_ff <= pca_pkg::sat32(prod >>> F);
      if (cmd.num) begin
         den_ff <= den;
         neg_ff <= ~num_full[65];
         rem_num_ff <= num_full[65] ? NUMW'(-num_full) : NUMW'(num_full);
         rem_ff <= '0;
         quo_ff <= '0;
         cnt_ff <= '0;
      end
      if (cmd.div_step) begin
         if (!rem_try[33]) begin
            rem_ff <= rem_try[32:0];
            quo_ff <= {quo_ff[NUMW-2:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[31:0], rem_num_ff[NUMW-1]};
            quo_ff <= {quo_ff[NUMW-2:0], 1'b0};
         end
         rem_num_ff <= {rem_num_ff[NUMW-2:0], 1'b0};
         cnt_ff <= cnt_ff + 6'd1;
      end
      if (cmd.div_end) d_ff <= (den_ff == 0) ? 32'sd0 : q_sat;
      if (cmd.sum) begin
         o_ff <= o;
         sat_ff <= (o != s);
      end
      if (cmd.back && sat_ff && cfg.ki != 0) begin
         i_ff <= pca_pkg::sat32(66'(o_ff) - 66'(p_ff) - 66'(d_ff));
      end
   end

   always_comb begin
      rsp_data.drive      = o_ff;
      rsp_data.prop_term  = p_ff;
      rsp_data.integ_term = i_ff;
      rsp_data.deriv_term = d_ff;
      rsp_data.saturated  = sat_ff;
   end

endmodule

// ===== design/pca_csr.sv =====
module pca_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [63:0]       csr_data,
   output pca_pkg::cfg_type  cfg
);

   pca_pkg::cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{kp: 31'd0, ki: 31'd0, kd: 31'd0, t: 31'd65536, tau: 31'd131072,
                     omax: 32'sd0, omin: 32'sd0, ilim: 64'd0};
      end else if (csr_valid) begin
         case (csr_index)
            pca_pkg::REG_KP:   cfg_ff.kp   <= csr_data[30:0];
            pca_pkg::REG_KI:   cfg_ff.ki   <= csr_data[30:0];
            pca_pkg::REG_KD:   cfg_ff.kd   <= csr_data[30:0];
            pca_pkg::REG_T:    cfg_ff.t    <= csr_data[30:0];
            pca_pkg::REG_TAU:  cfg_ff.tau  <= csr_data[30:0];
            pca_pkg::REG_OMAX: cfg_ff.omax <= csr_data[31:0];
            pca_pkg::REG_OMIN: cfg_ff.omin <= csr_data[31:0];
            pca_pkg::REG_ILIM: cfg_ff.ilim <= csr_data;
            default: ;
         endcase
      end
   end

endmodule

// ===== design/pid_controller_antiwindup.sv =====
// PID controller on signed Q16.16 samples with trapezoidal integral,
// filtered derivative on the measurement and output clamp with integrator
// back-calculation. One sample at a time: no new item is taken until the
// last result has been taken; a compute item uses a bit-serial divider in
// the derivative filter. The user must write registers through the csr_ port
// only while the block is idle; the block does not enforce it. The index is 3 bits wide.
module pid_controller_antiwindup (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pca_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pca_pkg::rsp_type  rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [63:0]       csr_data
);

   pca_pkg::cfg_type    cfg;
   pca_pkg::cmd_type    cmd;
   pca_pkg::status_type status;

   pca_csr u_csr (
      .clock, .reset, .csr_valid, .csr_ready, .csr_index, .csr_data, .cfg
   );

   pca_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_opcode(req_data.opcode), .req_stall,
      .rsp_valid, .rsp_stall, .status, .cmd
   );

   pca_datapath u_dp (
      .clock, .reset, .req_data, .cfg, .cmd, .status, .rsp_data
   );

endmodule
